@@ design/adpm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpm_pkg
// Shared widths, register indexes and small arithmetic helpers for the
// dither point marker.
// ----------------------------------------------------------------------------
package adpm_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 10;
    localparam int PIX_W      = 8;
    localparam int SET_W      = 7;
    localparam int DIM_W      = 11;
    localparam int SHARE_W    = 7;
    localparam int NUM_SLOTS  = 3;
    localparam int SLOT_W     = 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    localparam int OUT_DATA_W = 24;

    localparam logic [DIM_W-1:0] MIN_WIDTH_V  = 11'd4;
    localparam logic [DIM_W-1:0] MAX_WIDTH_V  = 11'd1024;
    localparam logic [DIM_W-1:0] MIN_HEIGHT_V = 11'd3;
    localparam logic [DIM_W-1:0] MAX_HEIGHT_V = 11'd1024;
    localparam logic [PIX_W-1:0] MID_GREY     = 8'd127;

    typedef logic [SLOT_W-1:0] t_slot;

    typedef enum logic [1:0] {
        CFG_LOW    = 2'd0,
        CFG_HIGH   = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic             is_point;
        logic             frame_end;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_result;

    // row modulo three, base-4 digit sum
    function automatic t_slot mod3_row(input logic [ROW_W-1:0] v);
        logic [3:0] s;
        logic [2:0] t;
        s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]) + 4'(v[9:8]);
        t = 3'(s[1:0]) + 3'(s[3:2]);
        if (t >= 3'd6) begin
            return 2'(t - 3'd6);
        end else if (t >= 3'd3) begin
            return 2'(t - 3'd3);
        end else begin
            return t[1:0];
        end
    endfunction

    function automatic t_slot slot_inc(input t_slot s);
        return (s == 2'd2) ? 2'd0 : 2'(s + 2'd1);
    endfunction

    function automatic logic [PIX_W-1:0] sat_add(input logic [PIX_W-1:0] v,
                                                 input logic signed [SHARE_W-1:0] s);
        logic signed [9:0] sum;
        sum = $signed({2'b00, v}) + $signed({{3{s[SHARE_W-1]}}, s});
        if (sum < 10'sd0) begin
            return 8'd0;
        end else if (sum > 10'sd255) begin
            return 8'd255;
        end else begin
            return sum[7:0];
        end
    endfunction

endpackage

@@ design/adpm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module adpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/atkinson_dither_point_marker_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atkinson_dither_point_marker_core
// Atkinson error diffusion over a three-line store, marks dark pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the s_axis channel, one beat per pixel,
// tuser set on the first pixel of a frame. Every input beat yields exactly
// one m_axis beat: tuser says the pixel two rows up in this column was
// quantized dark, tdata carries its row and column (zero when no pixel was
// finished), tlast marks the last pixel of a frame.
// Throughput is one pixel per cycle unless the output queue is full. Each
// pixel is held in stage 1, then its result is queued. The rate is set by
// the loop that carries the running pixel values along a row and by the
// three line RAMs, each with one read and one write port per cycle.
// Registers are written on the cfg channel (index, data), always ready;
// write them between frames or while idle.
// Reset clears position, registers and pipeline; the line RAMs hold no
// reset state and are filled by the pixel stream itself.
// A four-beat output queue decouples the receiver: while it stalls the
// queue fills and s_axis_tready drops once no room is left.
// ----------------------------------------------------------------------------
module atkinson_dither_point_marker_core import adpm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PIX_W-1:0]      s_axis_tdata,   // pixel
    input  logic                  s_axis_tuser,   // frame_start
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // point_row, point_col, zero pad
    output logic                  m_axis_tuser,   // is_point
    output logic                  m_axis_tlast,   // frame_end
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [DIM_W-1:0]      i_cfg_data
);

    // configuration
    logic [SET_W-1:0] r_low;
    logic [SET_W-1:0] r_high;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low    <= '0;
            r_high   <= 7'd127;
            r_width  <= 11'd640;
            r_height <= 11'd480;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LOW:    r_low    <= i_cfg_data[SET_W-1:0];
                CFG_HIGH:   r_high   <= i_cfg_data[SET_W-1:0];
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // position and stage 0
    logic [ROW_W-1:0] r_row_cnt, n_row_cnt;
    logic [COL_W-1:0] r_col_cnt, n_col_cnt;
    logic [DIM_W-1:0] w_eff, h_eff;
    logic [COL_W-1:0] w_m1, w_m3;
    logic [ROW_W-1:0] h_m1;
    logic [ROW_W-1:0] row0, row_sat;
    logic [COL_W-1:0] col0, col_sat;
    logic             last_col, proc0, wb0, fend0, accept;
    t_slot            cur_slot, slot_r, slot_m;
    logic [COL_W-1:0] col_r, col_m;

    always_comb begin
        w_eff = r_width;
        if (r_width < MIN_WIDTH_V) w_eff = MIN_WIDTH_V;
        if (r_width > MAX_WIDTH_V) w_eff = MAX_WIDTH_V;
        h_eff = r_height;
        if (r_height < MIN_HEIGHT_V) h_eff = MIN_HEIGHT_V;
        if (r_height > MAX_HEIGHT_V) h_eff = MAX_HEIGHT_V;
        w_m1 = COL_W'(w_eff - 11'd1);
        w_m3 = COL_W'(w_eff - 11'd3);
        h_m1 = ROW_W'(h_eff - 11'd1);

        row0 = s_axis_tuser ? '0 : r_row_cnt;
        col0 = s_axis_tuser ? '0 : r_col_cnt;
        col_sat = (col0 > w_m1) ? w_m1 : col0;
        row_sat = (row0 > h_m1) ? h_m1 : row0;
        cur_slot = mod3_row(row_sat);
        last_col = (col_sat >= w_m1);
        proc0 = (row_sat >= 10'd2) && (col_sat >= 10'd1) && (col_sat <= w_m3);
        wb0   = (row_sat >= 10'd2) && (col_sat >= 10'd1);

        fend0     = 1'b0;
        n_row_cnt = row_sat;
        n_col_cnt = col_sat + 10'd1;
        if (last_col) begin
            n_col_cnt = '0;
            if (row_sat >= h_m1) begin
                n_row_cnt = '0;
                fend0     = 1'b1;
            end else begin
                n_row_cnt = row_sat + 10'd1;
            end
        end

        // fetch ahead: row r at col+2, row r+1 at col+1; at row end the next row start
        if (last_col) begin
            slot_r = slot_inc(slot_inc(cur_slot));
            slot_m = cur_slot;
            col_r  = 10'd1;
            col_m  = 10'd0;
        end else begin
            slot_r = slot_inc(cur_slot);
            slot_m = slot_inc(slot_inc(cur_slot));
            col_r  = col_sat + 10'd2;
            col_m  = col_sat + 10'd1;
        end
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
            r_col_cnt <= '0;
        end else if (accept) begin
            r_row_cnt <= n_row_cnt;
            r_col_cnt <= n_col_cnt;
        end
    end

    // stage 1 registers
    logic             r_s1_valid;
    logic [ROW_W-1:0] r_s1_row;
    logic [COL_W-1:0] r_s1_col;
    logic             r_s1_proc, r_s1_wb, r_s1_fend;
    logic [PIX_W-1:0] r_s1_pix;
    t_slot            r_s1_slot_r, r_s1_slot_m, r_s1_slot_p, r_s1_slot_wb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_row     <= row_sat;
            r_s1_col     <= col_sat;
            r_s1_proc    <= proc0;
            r_s1_wb      <= wb0;
            r_s1_fend    <= fend0;
            r_s1_pix     <= s_axis_tdata;
            r_s1_slot_r  <= slot_r;
            r_s1_slot_m  <= slot_m;
            r_s1_slot_p  <= cur_slot;
            r_s1_slot_wb <= slot_inc(slot_inc(cur_slot));
        end
    end

    // diffusion loop
    logic [PIX_W-1:0] r_a, r_b, r_p, r_q;
    logic [PIX_W-1:0] rd_data [NUM_SLOTS];
    logic [PIX_W-1:0] val_r, val_m;
    logic             r_fwd_r_hit, r_fwd_m_hit;
    logic [PIX_W-1:0] r_fwd_r_data, r_fwd_m_data;
    logic signed [8:0] dark, light, level;
    logic signed [9:0] err, err_adj, share_full;
    logic signed [SHARE_W-1:0] share;
    logic             is_low, is_point;
    logic [PIX_W-1:0] n_a, n_b, n_p, n_q, wb_data, pix_data;
    logic [COL_W-1:0] wb_col;
    logic             pix_we, wb_we;

    always_comb begin
        val_r = r_fwd_r_hit ? r_fwd_r_data : rd_data[r_s1_slot_r];
        val_m = r_fwd_m_hit ? r_fwd_m_data : rd_data[r_s1_slot_m];

        dark  = $signed({1'b0, r_low, 1'b0});
        light = $signed({1'b0, r_high, 1'b0});
        if (light < dark) dark = light - 9'sd1;
        is_low     = (r_a < MID_GREY);
        level      = is_low ? dark : light;
        err        = $signed({2'b00, r_a}) - $signed({level[8], level});
        err_adj    = err[9] ? (err + 10'sd7) : err;
        share_full = err_adj >>> 3;
        share      = r_s1_proc ? share_full[SHARE_W-1:0] : '0;
        is_point   = r_s1_proc && (is_low || (light == dark));

        n_a      = sat_add(r_b, share);
        n_b      = sat_add(val_r, share);
        wb_data  = sat_add(r_p, share);
        n_p      = sat_add(r_q, share);
        n_q      = sat_add(val_m, share);
        pix_data = sat_add(r_s1_pix, share);
        wb_col   = r_s1_col - 10'd1;
        pix_we   = r_s1_valid;
        wb_we    = r_s1_valid && r_s1_wb;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_a <= n_a;
            r_b <= n_b;
            r_p <= n_p;
            r_q <= n_q;
        end
    end

    // same-cycle write to a fetched entry
    always_ff @(posedge i_clk) begin
        r_fwd_r_hit  <= 1'b0;
        r_fwd_m_hit  <= 1'b0;
        r_fwd_r_data <= pix_data;
        r_fwd_m_data <= pix_data;
        if (pix_we && r_s1_slot_p == slot_r && r_s1_col == col_r) begin
            r_fwd_r_hit <= 1'b1;
        end
        if (wb_we && r_s1_slot_wb == slot_r && wb_col == col_r) begin
            r_fwd_r_hit  <= 1'b1;
            r_fwd_r_data <= wb_data;
        end
        if (pix_we && r_s1_slot_p == slot_m && r_s1_col == col_m) begin
            r_fwd_m_hit <= 1'b1;
        end
        if (wb_we && r_s1_slot_wb == slot_m && wb_col == col_m) begin
            r_fwd_m_hit  <= 1'b1;
            r_fwd_m_data <= wb_data;
        end
    end

    // one line RAM per slot
    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_line
        logic             we;
        logic [COL_W-1:0] waddr, raddr;
        logic [PIX_W-1:0] wdata;

        always_comb begin
            raddr = (slot_r == SLOT_W'(k)) ? col_r : col_m;
            if (r_s1_slot_p == SLOT_W'(k)) begin
                we    = pix_we;
                waddr = r_s1_col;
                wdata = pix_data;
            end else begin
                we    = wb_we && (r_s1_slot_wb == SLOT_W'(k));
                waddr = wb_col;
                wdata = wb_data;
            end
        end

        adpm_ram #(
            .WIDTH(PIX_W),
            .DEPTH(MAX_WIDTH)
        ) u_ram (
            .i_clk  (i_clk),
            .i_we   (we),
            .i_waddr(waddr),
            .i_wdata(wdata),
            .i_raddr(raddr),
            .o_rdata(rd_data[k])
        );
    end

    // output queue
    t_result            r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CW-1:0] r_cnt, n_cnt;
    t_result            res;
    logic               pop;

    always_comb begin
        res.is_point  = is_point;
        res.frame_end = r_s1_fend;
        res.row       = r_s1_proc ? (r_s1_row - 10'd2) : '0;
        res.col       = r_s1_proc ? r_s1_col : '0;
        pop           = m_axis_tvalid && m_axis_tready;
        n_cnt         = r_cnt + FIFO_CW'(r_s1_valid) - FIFO_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (r_s1_valid) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop)        r_rd_ptr <= r_rd_ptr + 1'b1;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_fifo[r_wr_ptr] <= res;
        end
    end

    assign s_axis_tready = (r_cnt + FIFO_CW'(r_s1_valid)) < FIFO_CW'(FIFO_DEPTH);
    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tuser  = r_fifo[r_rd_ptr].is_point;
    assign m_axis_tlast  = r_fifo[r_rd_ptr].frame_end;
    assign m_axis_tdata  = {4'b0000, r_fifo[r_rd_ptr].col, r_fifo[r_rd_ptr].row};

endmodule

@@ verif/atkinson_dither_point_marker_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atkinson_dither_point_marker_core_tb
// Self-checking bench for the Atkinson dither point marker.
// ----------------------------------------------------------------------------
// Streams grey pixel frames of many sizes and level settings into the core.
// A dither model tracks the three-line store and the raster position, and
// predicts one output beat per pixel. Each output beat is compared with the
// oldest prediction. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module atkinson_dither_point_marker_core_tb;
    import adpm_pkg::*;

    class point_checker;
        byte unsigned    line_mem[NUM_SLOTS*MAX_WIDTH];
        int unsigned     row_pos;
        int unsigned     col_pos;
        int unsigned     low_set;
        int unsigned     high_set;
        int unsigned     width_reg;
        int unsigned     height_reg;
        t_result         pending_points[$];
        int              errors;

        function new();
            foreach (line_mem[i]) line_mem[i] = 8'd0;
            row_pos    = 0;
            col_pos    = 0;
            low_set    = 0;
            high_set   = 127;
            width_reg  = 640;
            height_reg = 480;
            errors     = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [DIM_W-1:0] v);
            case (idx)
                CFG_LOW:    low_set    = v[SET_W-1:0];
                CFG_HIGH:   high_set   = v[SET_W-1:0];
                CFG_WIDTH:  width_reg  = v;
                CFG_HEIGHT: height_reg = v;
                default:    ;
            endcase
        endfunction

        function int unsigned frame_width();
            int unsigned w;
            w = width_reg;
            if (w < 4) w = 4;
            if (w > MAX_WIDTH) w = MAX_WIDTH;
            if (w > 1024) w = 1024;
            return w;
        endfunction

        function int unsigned frame_height();
            int unsigned h;
            h = height_reg;
            if (h < 3) h = 3;
            if (h > 1024) h = 1024;
            return h;
        endfunction

        function void diffuse(int unsigned slot, int unsigned col, int share);
            int unsigned idx;
            int          v;
            idx = slot * MAX_WIDTH + col;
            if (idx >= NUM_SLOTS * MAX_WIDTH) return;
            v = int'(line_mem[idx]) + share;
            if (v > 255) v = 255;
            if (v < 0) v = 0;
            line_mem[idx] = v[7:0];
        endfunction

        function void note_pixel(logic [PIX_W-1:0] pix, logic fs);
            int unsigned w, h, row, col, r, s0, s1, s2;
            int          old, dark, light, level, share;
            t_result     res;
            w   = frame_width();
            h   = frame_height();
            row = row_pos;
            col = col_pos;
            res = '0;
            if (fs) begin
                row = 0;
                col = 0;
            end
            if (col > w - 1) col = w - 1;
            if (row > h - 1) row = h - 1;
            line_mem[(row % 3) * MAX_WIDTH + col] = pix;
            if (row >= 2 && col >= 1 && col <= w - 3) begin
                r     = row - 2;
                s0    = r % 3;
                s1    = (r + 1) % 3;
                s2    = row % 3;
                old   = int'(line_mem[s0 * MAX_WIDTH + col]);
                dark  = 2 * int'(low_set);
                light = 2 * int'(high_set);
                if (light < dark) dark = light - 1;
                level = (old < 127) ? dark : light;
                share = (old - level) / 8;
                diffuse(s0, col + 1, share);
                diffuse(s0, col + 2, share);
                diffuse(s1, col - 1, share);
                diffuse(s1, col, share);
                diffuse(s1, col + 1, share);
                diffuse(s2, col, share);
                res.is_point = (level == dark);
                res.row      = r[ROW_W-1:0];
                res.col      = col[COL_W-1:0];
            end
            if (col >= w - 1) begin
                col = 0;
                if (row >= h - 1) begin
                    row = 0;
                    res.frame_end = 1'b1;
                end else begin
                    row++;
                end
            end else begin
                col++;
            end
            row_pos = row & 10'h3ff;
            col_pos = col & 10'h3ff;
            pending_points.push_back(res);
        endfunction

        function void check_point(logic [OUT_DATA_W-1:0] data, logic user, logic last);
            t_result exp;
            if (pending_points.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat: tdata=%h tuser=%b tlast=%b",
                                           data, user, last);
                return;
            end
            exp = pending_points.pop_front();
            if (data[9:0] !== exp.row || data[19:10] !== exp.col || data[23:20] !== 4'd0 ||
                user !== exp.is_point || last !== exp.frame_end) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: exp row=%0d col=%0d pt=%b end=%b", exp.row, exp.col,
                             exp.is_point, exp.frame_end);
                    $display("          got row=%0d col=%0d pad=%h pt=%b end=%b", data[9:0],
                             data[19:10], data[23:20], user, last);
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [PIX_W-1:0]      s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [1:0]            i_cfg_index   = '0;
    logic [DIM_W-1:0]      i_cfg_data    = '0;

    point_checker chk = new();
    int  items_sent  = 0;
    int  stall_left  = 0;
    bit  tx_idle_on  = 1'b1;
    bit  rx_idle_on  = 1'b1;

    atkinson_dither_point_marker_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // pixel
        .s_axis_tuser  (s_axis_tuser),   // frame_start
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // point_row, point_col, zero pad
        .m_axis_tuser  (m_axis_tuser),   // is_point
        .m_axis_tlast  (m_axis_tlast),   // frame_end
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic int pick_gap(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd126;
            3:       return 8'd127;
            4:       return 8'd128;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // output side: check accepted beats, random backpressure
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            chk.check_point(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (rx_idle_on && $urandom_range(0, 9) == 0) stall_left = pick_gap(1'b1) + 1;
        end
    end

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (chk.pending_points.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input logic [DIM_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        chk.write_reg(idx, v);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        int gap;
        gap = pick_gap(tx_idle_on);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= fs;
        do @(posedge i_clk); while (!s_axis_tready);
        chk.note_pixel(pix, fs);
        items_sent++;
        if ($urandom_range(0, 199) == 0) drain();
    endtask

    task automatic configure(input logic [DIM_W-1:0] lo, input logic [DIM_W-1:0] hi,
                             input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        drain();
        write_cfg(CFG_LOW, lo);
        write_cfg(CFG_HIGH, hi);
        write_cfg(CFG_WIDTH, w);
        write_cfg(CFG_HEIGHT, h);
    endtask

    // first pixel of a phase always restarts the frame
    task automatic send_frames(input int nframes);
        int n;
        n = chk.frame_width() * chk.frame_height();
        for (int f = 0; f < nframes; f++) begin
            for (int i = 0; i < n; i++) begin
                if (i == 0) send_pixel(pick_pixel(), (f == 0) ? 1'b1 : 1'($urandom_range(0, 1)));
                else send_pixel(pick_pixel(), $urandom_range(0, 79) == 0);
            end
        end
    endtask

    function automatic logic [DIM_W-1:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return 11'd0;
            1:       return 11'd127;
            default: return $urandom_range(0, 2047);
        endcase
    endfunction

    initial begin
        logic [PIX_W-1:0] dir_pix[12];
        logic [DIM_W-1:0] w, h;
        dir_pix = '{8'd0, 8'd255, 8'd127, 8'd126, 8'd1, 8'd254,
                    8'd128, 8'd0, 8'd255, 8'd0, 8'd255, 8'd127};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // smallest frame, full level range
        configure(11'd0, 11'd127, 11'd4, 11'd3);
        foreach (dir_pix[i]) send_pixel(dir_pix[i], i == 0);
        // equal levels: every processed pixel is a point
        configure(11'd50, 11'd50, 11'd4, 11'd3);
        send_frames(1);

        // height shrinks mid-frame, row position saturates
        configure(pick_level(), pick_level(), 11'd6, 11'd8);
        for (int i = 0; i < 32; i++) send_pixel(pick_pixel(), i == 0);
        drain();
        write_cfg(CFG_HEIGHT, 11'd3);
        write_cfg(CFG_LOW, pick_level());
        for (int i = 0; i < 4 + 18; i++) send_pixel(pick_pixel(), 1'b0);

        while (items_sent < 700) begin
            w = $urandom_range(4, 12);
            h = $urandom_range(3, 7);
            case ($urandom_range(0, 9))
                0:       w = $urandom_range(0, 3);
                1:       h = $urandom_range(0, 2);
                default: ;
            endcase
            tx_idle_on = $urandom_range(0, 4) != 0;
            rx_idle_on = $urandom_range(0, 4) != 0;
            configure(pick_level(), pick_level(), w, h);
            send_frames($urandom_range(1, 3));
        end

        // widest and tallest frames
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        configure(pick_level(), pick_level(), 11'd2047, 11'd0);
        send_frames(1);
        configure(pick_level(), pick_level(), 11'd0, 11'd2047);
        send_frames(1);

        drain();
        repeat (10) @(posedge i_clk);
        if (chk.errors == 0 && chk.pending_points.size() == 0) begin
            $display("atkinson_dither_point_marker_core_tb OK");
        end else begin
            $display("atkinson_dither_point_marker_core_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("atkinson_dither_point_marker_core_tb NOT OK");
        $finish;
    end

endmodule
